>>> src/fnsp_pkg.sv
`timescale 1ns / 1ps
package fnsp_pkg;

	localparam int POS_BITS    = 32;
	localparam int RECORD_BITS = 24;

	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 2;
	localparam int REC_W   = 24;
	localparam int FPOS_W  = 32;
	localparam int CIDX_W  = 1;

	localparam logic [POS_BITS-1:0]    POS_MAX = {POS_BITS{1'b1}};
	localparam logic [RECORD_BITS-1:0] REC_MAX = {RECORD_BITS{1'b1}};

	localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LEAD  = 2'd2;

	localparam logic [CHAR_W-1:0] SEP_CHAR = 8'd36;
	localparam logic [CHAR_W-1:0] NEWLINE  = 8'd10;

	localparam logic [CHAR_W-1:0] SPLIT_RST  = 8'd78;
	localparam logic [CHAR_W-1:0] HEADER_RST = 8'd62;

	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_HEADER = 2'd1;
	localparam logic [1:0] MODE_SEQ    = 2'd2;

	localparam logic [CIDX_W-1:0] CFG_SPLIT  = 1'd0;
	localparam logic [CIDX_W-1:0] CFG_HEADER = 1'd1;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_END  = 1'b1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] out_char;
		logic [REC_W-1:0]  record_index;
		logic [FPOS_W-1:0] frag_start;
		logic [FPOS_W-1:0] frag_end;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

>>> src/fnsp_if.sv
`timescale 1ns / 1ps
interface fnsp_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [fnsp_pkg::CHAR_W-1:0]   data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

interface fnsp_out_if;
	logic                          valid;
	logic                          ready;
	logic [fnsp_pkg::KIND_W-1:0]   kind;
	logic [fnsp_pkg::CHAR_W-1:0]   out_char;
	logic [fnsp_pkg::REC_W-1:0]    record_index;
	logic [fnsp_pkg::FPOS_W-1:0]   frag_start;
	logic [fnsp_pkg::FPOS_W-1:0]   frag_end;
	logic                          last;

	modport source (output valid, kind, out_char, record_index, frag_start, frag_end, last,
		input ready);
	modport sink   (input valid, kind, out_char, record_index, frag_start, frag_end, last,
		output ready);
endinterface

>>> src/fnsp_core.sv
`timescale 1ns / 1ps
module fnsp_core (
	input  logic                        clk,
	input  logic                        arst_n,
	fnsp_in_if.sink                     in_ch,
	input  logic                        room,
	input  logic [fnsp_pkg::CHAR_W-1:0] split_char,
	input  logic [fnsp_pkg::CHAR_W-1:0] header_mark,
	output fnsp_pkg::push_t             push
);

	logic                            valid_s1;
	logic                            action_s1;
	logic [fnsp_pkg::CHAR_W-1:0]     byte_s1;

	logic [1:0]                          mode_q, mode_d;
	logic [fnsp_pkg::POS_BITS-1:0]       pos_q, pos_d;
	logic                                open_q, open_d;
	logic [fnsp_pkg::POS_BITS-1:0]       begin_q, begin_d;
	logic [fnsp_pkg::RECORD_BITS-1:0]    rec_q, rec_d;
	logic                                started_q, started_d;

	logic            fire;
	logic            ev_close;
	logic            ev_char;
	fnsp_pkg::result_t lead_r, ev_r;

	assign fire        = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			action_s1 <= in_ch.action;
			byte_s1   <= in_ch.data_byte;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		open_d    = open_q;
		begin_d   = begin_q;
		rec_d     = rec_q;
		started_d = 1'b1;
		ev_close  = 1'b0;
		ev_char   = 1'b0;
		if (action_s1 == fnsp_pkg::ACT_END) begin
			ev_close  = open_q;
			mode_d    = fnsp_pkg::MODE_START;
			pos_d     = '0;
			open_d    = 1'b0;
			begin_d   = '0;
			rec_d     = '0;
			started_d = 1'b0;
		end else if (byte_s1 == fnsp_pkg::NEWLINE) begin
			mode_d = fnsp_pkg::MODE_START;
		end else if (mode_q == fnsp_pkg::MODE_HEADER) begin
			mode_d = mode_q;
		end else if (mode_q == fnsp_pkg::MODE_START && byte_s1 == header_mark) begin
			ev_close = open_q;
			open_d   = 1'b0;
			if (rec_q != fnsp_pkg::REC_MAX) begin
				rec_d = rec_q + 1'b1;
			end
			pos_d  = '0;
			mode_d = fnsp_pkg::MODE_HEADER;
		end else begin
			mode_d = fnsp_pkg::MODE_SEQ;
			if (byte_s1 == split_char) begin
				ev_close = open_q;
				open_d   = 1'b0;
			end else begin
				if (!open_q) begin
					open_d  = 1'b1;
					begin_d = pos_q;
				end
				ev_char = 1'b1;
			end
			if (pos_q != fnsp_pkg::POS_MAX) begin
				pos_d = pos_q + 1'b1;
			end
		end
	end

	always_comb begin
		lead_r.kind         = fnsp_pkg::KIND_LEAD;
		lead_r.out_char     = fnsp_pkg::SEP_CHAR;
		lead_r.record_index = fnsp_pkg::REC_W'(rec_q);
		lead_r.frag_start   = '0;
		lead_r.frag_end     = '0;
		lead_r.last         = !(ev_close || ev_char);

		ev_r.record_index = fnsp_pkg::REC_W'(rec_q);
		ev_r.last         = 1'b1;
		if (ev_close) begin
			ev_r.kind       = fnsp_pkg::KIND_CLOSE;
			ev_r.out_char   = fnsp_pkg::SEP_CHAR;
			ev_r.frag_start = fnsp_pkg::FPOS_W'(begin_q);
			ev_r.frag_end   = fnsp_pkg::FPOS_W'(pos_q);
		end else begin
			ev_r.kind       = fnsp_pkg::KIND_CHAR;
			ev_r.out_char   = byte_s1;
			ev_r.frag_start = '0;
			ev_r.frag_end   = '0;
		end

		// leading separator goes first, the byte's own result after it
		push.r1 = ev_r;
		if (!started_q) begin
			push.r0 = lead_r;
			push.n  = (ev_close || ev_char) ? 2'd2 : 2'd1;
		end else begin
			push.r0 = ev_r;
			push.n  = (ev_close || ev_char) ? 2'd1 : 2'd0;
		end
		if (!fire) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= fnsp_pkg::MODE_START;
			pos_q     <= '0;
			open_q    <= 1'b0;
			begin_q   <= '0;
			rec_q     <= '0;
			started_q <= 1'b0;
		end else if (fire) begin
			mode_q    <= mode_d;
			pos_q     <= pos_d;
			open_q    <= open_d;
			begin_q   <= begin_d;
			rec_q     <= rec_d;
			started_q <= started_d;
		end
	end

endmodule

>>> src/fnsp_res_fifo.sv
`timescale 1ns / 1ps
module fnsp_res_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  fnsp_pkg::push_t push,
	output logic            room,
	fnsp_out_if.source      out_ch
);

	fnsp_pkg::result_t mem_q [fnsp_pkg::FIFO_DEPTH];

	logic [fnsp_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [fnsp_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [fnsp_pkg::FIFO_AW:0]   count_q;
	logic                         pop;
	logic [fnsp_pkg::FIFO_AW-1:0] wr_ptr_1;

	// two free slots so a two-result request always fits
	assign room     = count_q <= (fnsp_pkg::FIFO_AW + 1)'(fnsp_pkg::FIFO_DEPTH - 2);
	assign pop      = out_ch.valid && out_ch.ready;
	assign wr_ptr_1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + fnsp_pkg::FIFO_AW'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (fnsp_pkg::FIFO_AW + 1)'(push.n)
				- (fnsp_pkg::FIFO_AW + 1)'(pop);
		end
	end

	assign out_ch.valid        = count_q != '0;
	assign out_ch.kind         = mem_q[rd_ptr_q].kind;
	assign out_ch.out_char     = mem_q[rd_ptr_q].out_char;
	assign out_ch.record_index = mem_q[rd_ptr_q].record_index;
	assign out_ch.frag_start   = mem_q[rd_ptr_q].frag_start;
	assign out_ch.frag_end     = mem_q[rd_ptr_q].frag_end;
	assign out_ch.last         = mem_q[rd_ptr_q].last;

endmodule

>>> src/fasta_n_split_parser_top.sv
`timescale 1ns / 1ps
// channel   | dir | payload                                              | handshake
// in_ch     | in  | action, data_byte                                    | valid/ready
// out_ch    | out | kind, out_char, record_index, frag_start, frag_end,  | valid/ready
//           |     | last                                                 |
// cfg       | in  | cfg_index, cfg_data                                  | cfg_we only
//
// one byte per cycle while the result queue has room: an input register, then one pass of compare and counter logic
// that writes up to two results into a four-entry result queue
// a request with two results (the first byte of a stream) writes a leading separator ahead of its own result
// a request passes the input register, then the result queue, before its first result reaches out_ch
// input stalls only while the result queue has fewer than two free entries
// arst_n clears all parser state; registers return to 'N' and '>'
module fasta_n_split_parser_top (
	input  logic                        clk,
	input  logic                        arst_n,
	fnsp_in_if.sink                     in_ch,
	fnsp_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [fnsp_pkg::CIDX_W-1:0] cfg_index,
	input  logic [fnsp_pkg::CHAR_W-1:0] cfg_data
);

	logic [fnsp_pkg::CHAR_W-1:0] split_char_q;
	logic [fnsp_pkg::CHAR_W-1:0] header_mark_q;
	logic                        room;
	fnsp_pkg::push_t             push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_char_q  <= fnsp_pkg::SPLIT_RST;
			header_mark_q <= fnsp_pkg::HEADER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fnsp_pkg::CFG_SPLIT:  split_char_q  <= cfg_data;
				fnsp_pkg::CFG_HEADER: header_mark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fnsp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.room        (room),
		.split_char  (split_char_q),
		.header_mark (header_mark_q),
		.push        (push)
	);

	fnsp_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.out_ch (out_ch)
	);

endmodule

>>> src/fnsp_checker.sv
`timescale 1ns / 1ps
module fnsp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fnsp_pkg::KIND_W-1:0] kind,
	input logic [fnsp_pkg::CHAR_W-1:0] out_char,
	input logic [fnsp_pkg::FPOS_W-1:0] frag_start,
	input logic [fnsp_pkg::FPOS_W-1:0] frag_end,
	input logic                        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char)
			&& $stable(frag_start) && $stable(frag_end) && $stable(last))
		else $error("result changed while stalled");

	a_sep_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == fnsp_pkg::KIND_CLOSE || kind == fnsp_pkg::KIND_LEAD)
			|-> out_char == fnsp_pkg::SEP_CHAR)
		else $error("separator without dollar char");

	a_frag_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == fnsp_pkg::KIND_CLOSE |-> frag_start < frag_end)
		else $error("closed fragment is empty or reversed");

	a_no_coords: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != fnsp_pkg::KIND_CLOSE |-> frag_start == '0 && frag_end == '0)
		else $error("coordinates on a non-closing result");

endmodule

bind fasta_n_split_parser_top fnsp_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.kind       (out_ch.kind),
	.out_char   (out_ch.out_char),
	.frag_start (out_ch.frag_start),
	.frag_end   (out_ch.frag_end),
	.last       (out_ch.last)
);
